### rtl/core/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// text_console_writer_macros.svh
// Assertion macros used by the console writer top module.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTH
// Condition must hold at every clock edge out of reset
`define TCW_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant");
// Antecedent implies consequent in the same cycle
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// Antecedent implies consequent in the next cycle
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define TCW_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int CELL_AW    = 11;

	// Field widths
	localparam int TYPE_W = 2;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;

	// Character codes
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

	// Request kinds
	typedef enum logic [TYPE_W-1:0] {
		REQ_PUT  = 2'd0,
		REQ_READ = 2'd1,
		REQ_LOAD = 2'd2
	} req_kind_t;

	// Cursor view handed from the cursor unit to the controller
	typedef struct packed {
		logic [COL_W-1:0]   cur_col;
		logic [ROW_W-1:0]   cur_row;
		logic [CELL_AW-1:0] cell_addr;
		logic [COL_W-1:0]   nxt_col;
		logic [ROW_W-1:0]   nxt_row;
		logic               full;
	} cursor_info_t;

endpackage

### rtl/core/tcw_req_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  req_type;
	logic [CHAR_W-1:0]  char_code;
	logic [CELL_AW-1:0] cell_address;
	logic [CELL_W-1:0]  cell_value;

	modport source (
		output valid, req_type, char_code, cell_address, cell_value,
		input  ready
	);

	modport sink (
		input  valid, req_type, char_code, cell_address, cell_value,
		output ready
	);

endinterface

### rtl/core/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: valid/ready handshake with cell data and cursor.
// ----------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_data;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;

	modport source (
		output valid, cell_data, cursor_column, cursor_row,
		input  ready
	);

	modport sink (
		input  valid, cell_data, cursor_column, cursor_row,
		output ready
	);

endinterface

### rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console writer: cell buffer in two RAMs (attribute, glyph) and cursor.
// ----------------------------------------------------------------------------
// Put and load: one cycle per request while the response is drained, response registered at the accept edge.
// Read: the registered RAM read is followed by ST_RDWAIT, which loads the response; no request is taken there.
// A put that fills the screen starts a glyph sweep to spaces over all 2000 cells, one cell a cycle.
// After reset both RAMs are zeroed by a sweep over all 2000 cells; no request is taken during it.
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_RDWAIT,
		ST_CLEAR
	} state_t;

	state_t             state_q;
	logic [CELL_AW-1:0] sweep_q;
	logic               rd_ok_q;
	logic               rsp_valid_q;
	logic [CELL_W-1:0]  rsp_data_q;
	logic [COL_W-1:0]   rsp_col_q;
	logic [ROW_W-1:0]   rsp_row_q;

	cursor_info_t       cur;
	logic               accept;
	logic               pop;
	logic               rsp_set;
	logic               is_put;
	logic               is_read;
	logic               is_load;
	logic               addr_ok;
	logic               sweep_last;

	logic               attr_we;
	logic               glyph_we;
	logic [CELL_AW-1:0] waddr;
	logic [CHAR_W-1:0]  attr_wdata;
	logic [CHAR_W-1:0]  glyph_wdata;
	logic [CHAR_W-1:0]  attr_rdata;
	logic [CHAR_W-1:0]  glyph_rdata;

	logic               cur_in_range;
	logic               cur_home;
	logic               sweeping;
	logic               put_full;

	// Handshake and request decode
	assign pop        = rsp_valid_q && rsp.ready;
	assign req.ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept     = req.valid && req.ready;
	assign is_put     = (req.req_type == REQ_PUT);
	assign is_read    = (req.req_type == REQ_READ);
	assign is_load    = (req.req_type == REQ_LOAD);
	assign addr_ok    = (req.cell_address < CELL_AW'(CELL_COUNT));
	assign sweep_last = (sweep_q == CELL_AW'(CELL_COUNT - 1));
	// response register loads a new response this cycle
	assign rsp_set    = (accept && !is_read) || (state_q == ST_RDWAIT);

	tcw_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.put_en    (accept && is_put),
		.char_code (req.char_code),
		.info      (cur)
	);

	// RAM write port selection
	always_comb begin
		attr_we     = 1'b0;
		glyph_we    = 1'b0;
		waddr       = sweep_q;
		attr_wdata  = '0;
		glyph_wdata = '0;
		unique case (state_q)
			ST_INIT: begin
				attr_we  = 1'b1;
				glyph_we = 1'b1;
			end
			ST_CLEAR: begin
				glyph_we    = 1'b1;
				glyph_wdata = SPACE_CODE;
			end
			ST_IDLE: begin
				if (accept && is_put) begin
					glyph_we    = (req.char_code != NEWLINE_CODE);
					waddr       = cur.cell_addr;
					glyph_wdata = req.char_code;
				end else if (accept && is_load) begin
					attr_we     = addr_ok;
					glyph_we    = addr_ok;
					waddr       = req.cell_address;
					attr_wdata  = req.cell_value[CELL_W-1:CHAR_W];
					glyph_wdata = req.cell_value[CHAR_W-1:0];
				end
			end
			ST_RDWAIT: begin
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELL_COUNT)) u_attr_ram (
		.clk   (clk),
		.we    (attr_we),
		.waddr (waddr),
		.wdata (attr_wdata),
		.raddr (req.cell_address),
		.rdata (attr_rdata)
	);

	tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELL_COUNT)) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (waddr),
		.wdata (glyph_wdata),
		.raddr (req.cell_address),
		.rdata (glyph_rdata)
	);

	// Control state, sweep counter and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			rd_ok_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
			rsp_col_q   <= '0;
			rsp_row_q   <= '0;
		end else begin
			if (pop && !rsp_set) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + CELL_AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_ok_q <= addr_ok;
						if (is_read) begin
							state_q <= ST_RDWAIT;
						end else begin
							rsp_valid_q <= 1'b1;
							rsp_data_q  <= '0;
							rsp_col_q   <= is_put ? cur.nxt_col : cur.cur_col;
							rsp_row_q   <= is_put ? cur.nxt_row : cur.cur_row;
							if (is_put && cur.full) begin
								state_q <= ST_CLEAR;
							end
						end
					end
				end
				ST_RDWAIT: begin
					rsp_valid_q <= 1'b1;
					rsp_data_q  <= rd_ok_q ? {attr_rdata, glyph_rdata} : '0;
					rsp_col_q   <= cur.cur_col;
					rsp_row_q   <= cur.cur_row;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.cell_data     = rsp_data_q;
	assign rsp.cursor_column = rsp_col_q;
	assign rsp.cursor_row    = rsp_row_q;

	// Checks
	assign cur_in_range = (cur.cur_col < COL_W'(COLUMNS)) && (cur.cur_row < ROW_W'(ROWS));
	assign cur_home     = (cur.cur_col == '0) && (cur.cur_row == '0);
	assign sweeping     = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign put_full     = accept && is_put && cur.full;

	`TCW_ASSERT_ALWAYS(a_cursor_range, clk, arst_n, cur_in_range)
	`TCW_ASSERT_IMP(a_sweep_blocks, clk, arst_n, sweeping, !req.ready && (sweep_q < CELL_AW'(CELL_COUNT)))
	`TCW_ASSERT_NXT(a_read_slot_free, clk, arst_n, accept && is_read, !rsp_valid_q && (state_q == ST_RDWAIT))
	`TCW_ASSERT_NXT(a_full_clears, clk, arst_n, put_full, (state_q == ST_CLEAR) && (sweep_q == '0) && cur_home)

endmodule

### rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Write cursor: current position, cell index and position after a put.
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              put_en,
	input  logic [CHAR_W-1:0] char_code,
	output cursor_info_t      info
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_inc;
	logic [ROW_W-1:0] row_inc;
	logic [COL_W-1:0] nxt_col;
	logic [ROW_W-1:0] nxt_row;
	logic             full;

	assign col_inc = col_q + COL_W'(1);
	assign row_inc = row_q + ROW_W'(1);

	// Newline, column wrap, then screen-full wrap to the origin
	always_comb begin
		nxt_col = col_inc;
		nxt_row = row_q;
		if (char_code == NEWLINE_CODE || col_inc >= COL_W'(COLUMNS)) begin
			nxt_col = '0;
			nxt_row = row_inc;
		end
		full = (nxt_row >= ROW_W'(ROWS));
		if (full) begin
			nxt_col = '0;
			nxt_row = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (put_en) begin
			col_q <= nxt_col;
			row_q <= nxt_row;
		end
	end

	assign info.cur_col   = col_q;
	assign info.cur_row   = row_q;
	assign info.cell_addr = CELL_AW'(row_q) * CELL_AW'(COLUMNS) + CELL_AW'(col_q);
	assign info.nxt_col   = nxt_col;
	assign info.nxt_row   = nxt_row;
	assign info.full      = full;

endmodule
